### src/cfrm_pkg.sv
// Shared types, codes and constants of the counter FIFO rate monitor.
`default_nettype none
package cfrm_pkg;

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 32;
    localparam int RATE_W   = 39;
    localparam int STATE_W  = 3;
    localparam int IVL_W    = 3;
    localparam int NUM_W    = 6;
    localparam int MAXW_W   = 10;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 10;
    localparam int MULT_W   = 7;
    localparam int LOAD_W   = 10;
    localparam int DIV_CNT_W = 4;
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = 1;
    localparam int Q_CW     = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WORD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd3;

    localparam logic [CFG_IX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_NUM      = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_MAXW     = 2'd2;

    localparam logic [IVL_W-1:0]  IVL_RESET  = 3'd0;
    localparam logic [NUM_W-1:0]  NUM_RESET  = 6'd24;
    localparam logic [MAXW_W-1:0] MAXW_RESET = 10'd480;
    localparam logic [IVL_W-1:0]  IVL_OFF    = 3'd0;

    localparam logic [VAL_W-1:0] LOAD_ERROR = 32'hFFFF_FFFF;

    localparam logic [STATE_W-1:0] ST_BOARD_ERROR = 3'd0;
    localparam logic [STATE_W-1:0] ST_EMPTY       = 3'd1;
    localparam logic [STATE_W-1:0] ST_SINGLE      = 3'd2;
    localparam logic [STATE_W-1:0] ST_MULTIPLE    = 3'd3;
    localparam logic [STATE_W-1:0] ST_OUTDATED    = 3'd4;
    localparam logic [STATE_W-1:0] ST_PARTIAL     = 3'd5;

    localparam logic RK_STATUS = 1'b0;
    localparam logic RK_RATE   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_WORD,
        OP_CLEAR,
        OP_RESET
    } t_op;

    typedef struct packed {
        logic err;
        logic empty;
        logic single;
        logic below;
        logic nz;
    } t_load_flags;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
        logic              last;
        t_load_flags       lf;
    } t_cmd;

    typedef struct packed {
        logic                result_kind;
        logic [IDX_W-1:0]    rate_index;
        logic [RATE_W-1:0]   rate_tenths;
        logic [STATE_W-1:0]  fifo_state;
        logic [VAL_W-1:0]    adjusted_load;
        logic                last_rate;
    } t_result;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_MOD,
        B_LDONE,
        B_RATE,
        B_RMW
    } t_bstate;

    // tenths-per-second factor for each interval code
    function automatic logic [MULT_W-1:0] rate_mult(input logic [IVL_W-1:0] code);
        logic [MULT_W-1:0] m;
        case (code)
            3'd1:    m = 7'd100;
            3'd2:    m = 7'd50;
            3'd3:    m = 7'd20;
            3'd4:    m = 7'd10;
            3'd5:    m = 7'd5;
            3'd6:    m = 7'd2;
            3'd7:    m = 7'd1;
            default: m = 7'd0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### src/cfrm_front.sv
// Front end: accepts input beats, decodes them and pre-classifies load reports.
`default_nettype none
module cfrm_front #(
    parameter int MAX_COUNTERS = 32
) (
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [cfrm_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [cfrm_pkg::IDX_W-1:0]     i_counter_index,
    input  wire logic [cfrm_pkg::VAL_W-1:0]     i_value,
    input  wire logic                           i_last_of_set,
    input  wire logic [cfrm_pkg::NUM_W-1:0]     i_num_counters,
    input  wire logic [cfrm_pkg::MAXW_W-1:0]    i_max_fifo_words,
    input  wire logic                           i_q_full,
    output logic                                o_q_push,
    output cfrm_pkg::t_cmd                      o_q_cmd
);

    logic w_in_range;
    logic w_keep;

    assign w_in_range = ({27'b0, i_counter_index} < 32'(MAX_COUNTERS));

    always_comb begin
        o_q_cmd.idx   = i_counter_index;
        o_q_cmd.value = i_value;
        o_q_cmd.last  = i_last_of_set;
        o_q_cmd.lf.err    = (i_value == cfrm_pkg::LOAD_ERROR);
        o_q_cmd.lf.empty  = (i_value == '0);
        o_q_cmd.lf.nz     = (i_num_counters != '0);
        o_q_cmd.lf.single = (i_num_counters != '0) &&
                            (i_value == {26'b0, i_num_counters});
        o_q_cmd.lf.below  = (i_value < {22'b0, i_max_fifo_words});
        w_keep = 1'b1;
        unique case (i_kind)
            cfrm_pkg::KIND_LOAD:  o_q_cmd.op = cfrm_pkg::OP_LOAD;
            cfrm_pkg::KIND_WORD: begin
                o_q_cmd.op = cfrm_pkg::OP_WORD;
                w_keep     = w_in_range;
            end
            cfrm_pkg::KIND_CLEAR: o_q_cmd.op = cfrm_pkg::OP_CLEAR;
            default: begin
                o_q_cmd.op = cfrm_pkg::OP_RESET;
                w_keep     = w_in_range;
            end
        endcase
    end

    assign o_in_ready = !i_q_full;
    // out-of-range words are taken and dropped here
    assign o_q_push   = i_in_valid && !i_q_full && w_keep;

endmodule
`default_nettype wire

### src/cfrm_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module cfrm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cfrm_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output cfrm_pkg::t_cmd      o_cmd
);

    cfrm_pkg::t_cmd                 r_mem [cfrm_pkg::Q_DEPTH];
    logic [cfrm_pkg::Q_AW-1:0]      r_wp;
    logic [cfrm_pkg::Q_AW-1:0]      r_rp;
    logic [cfrm_pkg::Q_CW-1:0]      r_count;

    assign o_full  = (r_count == cfrm_pkg::Q_CW'(cfrm_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### src/cfrm_mod.sv
// Bit-serial remainder unit: load modulo counters-per-set, one bit per cycle.
`default_nettype none
module cfrm_mod (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [cfrm_pkg::LOAD_W-1:0]    i_dividend,
    input  wire logic [cfrm_pkg::NUM_W-1:0]     i_divisor,
    output logic                                o_busy,
    output logic [cfrm_pkg::NUM_W-1:0]          o_rem
);

    logic                               r_busy;
    logic [cfrm_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [cfrm_pkg::LOAD_W-1:0]        r_sh;
    logic [cfrm_pkg::NUM_W-1:0]         r_rem;
    logic [cfrm_pkg::NUM_W-1:0]         r_div;
    logic [cfrm_pkg::NUM_W:0]           w_trial;
    logic [cfrm_pkg::NUM_W-1:0]         n_rem;

    always_comb begin
        w_trial = {r_rem, r_sh[cfrm_pkg::LOAD_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = cfrm_pkg::NUM_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[cfrm_pkg::NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= cfrm_pkg::DIV_CNT_W'(cfrm_pkg::LOAD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == cfrm_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[cfrm_pkg::LOAD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### src/cfrm_back.sv
// Back end: executes queued commands, keeps the counter store and the result register.
`default_nettype none
module cfrm_back #(
    parameter int MAX_COUNTERS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire cfrm_pkg::t_cmd                 i_q_cmd,
    output logic                                o_q_pop,
    input  wire logic [cfrm_pkg::IVL_W-1:0]     i_interval,
    input  wire logic [cfrm_pkg::NUM_W-1:0]     i_num_counters,
    input  wire logic                           i_drop_set,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output cfrm_pkg::t_result                   o_result
);

    localparam int AW = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;

    cfrm_pkg::t_bstate              r_state;
    cfrm_pkg::t_bstate              n_state;
    cfrm_pkg::t_cmd                 r_cmd;
    logic                           r_have_set;
    logic                           r_out_valid;
    cfrm_pkg::t_result              r_result;
    cfrm_pkg::t_result              n_result;
    logic [cfrm_pkg::VAL_W-1:0]     r_mem [MAX_COUNTERS];
    logic [cfrm_pkg::VAL_W-1:0]     r_rd;

    logic                           w_out_free;
    logic                           w_emit;
    logic                           w_need_mod;
    logic                           w_mod_start;
    logic                           w_mod_busy;
    logic [cfrm_pkg::NUM_W-1:0]     w_rem;
    logic                           w_out_wr;
    logic                           w_mem_re;
    logic                           w_mem_we;
    logic [AW-1:0]                  w_waddr;
    logic [AW-1:0]                  w_raddr;
    logic [cfrm_pkg::VAL_W-1:0]     w_wdata;
    logic [AW+cfrm_pkg::IDX_W-1:0]  w_q_idx;
    logic [AW+cfrm_pkg::IDX_W-1:0]  w_c_idx;
    logic [cfrm_pkg::VAL_W-1:0]     w_diff;
    logic [cfrm_pkg::RATE_W-1:0]    w_prod;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = r_have_set && (i_interval != cfrm_pkg::IVL_OFF);
    assign w_need_mod = r_cmd.lf.nz && !r_cmd.lf.err && !r_cmd.lf.empty &&
                        !r_cmd.lf.single && r_cmd.lf.below;
    assign w_q_idx    = {{AW{1'b0}}, i_q_cmd.idx};
    assign w_c_idx    = {{AW{1'b0}}, r_cmd.idx};
    assign w_diff     = r_cmd.value - r_rd;
    assign w_prod     = cfrm_pkg::RATE_W'(w_diff) *
                        cfrm_pkg::RATE_W'(cfrm_pkg::rate_mult(i_interval));

    cfrm_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_cmd.value[cfrm_pkg::LOAD_W-1:0]),
        .i_divisor  (i_num_counters),
        .o_busy     (w_mod_busy),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfrm_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        cfrm_pkg::OP_LOAD: n_state = cfrm_pkg::B_LOAD;
                        cfrm_pkg::OP_WORD: begin
                            if (w_emit) n_state = cfrm_pkg::B_RATE;
                        end
                        cfrm_pkg::OP_RESET: begin
                            if (r_have_set) n_state = cfrm_pkg::B_RMW;
                        end
                        default: n_state = cfrm_pkg::B_IDLE;
                    endcase
                end
            end
            cfrm_pkg::B_LOAD: begin
                if (w_need_mod) begin
                    n_state = cfrm_pkg::B_MOD;
                end else if (w_out_free) begin
                    n_state = cfrm_pkg::B_IDLE;
                end
            end
            cfrm_pkg::B_MOD: begin
                if (!w_mod_busy) n_state = cfrm_pkg::B_LDONE;
            end
            cfrm_pkg::B_LDONE, cfrm_pkg::B_RATE: begin
                if (w_out_free) n_state = cfrm_pkg::B_IDLE;
            end
            default: n_state = cfrm_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = (r_state == cfrm_pkg::B_IDLE) && i_q_valid;
        w_mod_start = (r_state == cfrm_pkg::B_LOAD) && w_need_mod;
        w_out_wr    = w_out_free &&
                      (((r_state == cfrm_pkg::B_LOAD) && !w_need_mod) ||
                       (r_state == cfrm_pkg::B_LDONE) ||
                       (r_state == cfrm_pkg::B_RATE));
        w_mem_re    = o_q_pop;
        w_raddr     = w_q_idx[AW-1:0];
        if (r_state == cfrm_pkg::B_RMW) begin
            w_mem_we = 1'b1;
            w_waddr  = w_c_idx[AW-1:0];
            w_wdata  = r_rd - r_cmd.value;
        end else begin
            w_mem_we = o_q_pop && (i_q_cmd.op == cfrm_pkg::OP_WORD);
            w_waddr  = w_q_idx[AW-1:0];
            w_wdata  = i_q_cmd.value;
        end
    end

    always_comb begin
        n_result               = '0;
        n_result.result_kind   = cfrm_pkg::RK_STATUS;
        n_result.adjusted_load = r_cmd.value;
        if (r_state == cfrm_pkg::B_RATE) begin
            n_result.result_kind   = cfrm_pkg::RK_RATE;
            n_result.rate_index    = r_cmd.idx;
            n_result.rate_tenths   = w_prod;
            n_result.last_rate     = r_cmd.last;
            n_result.adjusted_load = '0;
        end else if (r_state == cfrm_pkg::B_LDONE) begin
            if (w_rem == '0) begin
                n_result.fifo_state = cfrm_pkg::ST_MULTIPLE;
            end else begin
                n_result.fifo_state    = cfrm_pkg::ST_PARTIAL;
                n_result.adjusted_load = r_cmd.value +
                                         cfrm_pkg::VAL_W'(i_num_counters - w_rem);
            end
        end else begin
            if (r_cmd.lf.err) begin
                n_result.fifo_state = cfrm_pkg::ST_BOARD_ERROR;
            end else if (r_cmd.lf.empty) begin
                n_result.fifo_state = cfrm_pkg::ST_EMPTY;
            end else if (r_cmd.lf.single) begin
                n_result.fifo_state = cfrm_pkg::ST_SINGLE;
            end else if (!r_cmd.lf.below) begin
                n_result.fifo_state = cfrm_pkg::ST_OUTDATED;
            end else begin
                n_result.fifo_state = cfrm_pkg::ST_PARTIAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfrm_pkg::B_IDLE;
            r_have_set  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_drop_set) begin
                r_have_set <= 1'b0;
            end else if (o_q_pop && (i_q_cmd.op == cfrm_pkg::OP_CLEAR)) begin
                r_have_set <= 1'b0;
            end else if (o_q_pop && (i_q_cmd.op == cfrm_pkg::OP_WORD) && i_q_cmd.last) begin
                r_have_set <= 1'b1;
            end
            if (w_out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_out_wr) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rd <= r_mem[w_raddr];
        end
        if (w_mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

### src/counter_fifo_rate_monitor_top.sv
// Top level of the counter FIFO rate monitor: configuration registers and block wiring.
`default_nettype none
// Classifies FIFO load reports and turns streamed counter words into rates in
// tenths per second. Input beats pass a decoder into a two-entry queue, so up to
// two beats are taken while the back end works or a result waits to be taken.
// The back end runs one command at a time: a counter word that yields a rate, a
// reset word while a set is held, or a load whose class follows from compares
// alone reads the counter store as it is popped, then does the store write or
// writes the result register. A load report below max_fifo_words that needs the
// remainder by num_counters first waits on the 10-step bit-serial remainder unit.
// Clear items and the other counter and reset words finish as they are popped; words with an
// index at or above MAX_COUNTERS are dropped at the input. A result waiting to be
// taken holds the back end. Configuration writes are always ready and must only
// be issued while the block is idle.
module counter_fifo_rate_monitor_top #(
    parameter int MAX_COUNTERS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [cfrm_pkg::KIND_W-1:0]        i_kind,
    input  wire logic [cfrm_pkg::IDX_W-1:0]         i_counter_index,
    input  wire logic [cfrm_pkg::VAL_W-1:0]         i_value,
    input  wire logic                               i_last_of_set,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_result_kind,
    output logic [cfrm_pkg::IDX_W-1:0]              o_rate_index,
    output logic [cfrm_pkg::RATE_W-1:0]             o_rate_tenths,
    output logic [cfrm_pkg::STATE_W-1:0]            o_fifo_state,
    output logic [cfrm_pkg::VAL_W-1:0]              o_adjusted_load,
    output logic                                    o_last_rate,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [cfrm_pkg::CFG_IX_W-1:0]      i_cfg_index,
    input  wire logic [cfrm_pkg::CFG_D_W-1:0]       i_cfg_data
);

    logic [cfrm_pkg::IVL_W-1:0]     r_interval;
    logic [cfrm_pkg::NUM_W-1:0]     r_num_counters;
    logic [cfrm_pkg::MAXW_W-1:0]    r_max_fifo_words;
    logic                           w_cfg_wr;
    logic                           w_drop_set;
    logic                           w_q_full;
    logic                           w_q_push;
    logic                           w_q_pop;
    logic                           w_q_valid;
    cfrm_pkg::t_cmd                 w_push_cmd;
    cfrm_pkg::t_cmd                 w_head_cmd;
    cfrm_pkg::t_result              w_result;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign w_drop_set  = w_cfg_wr && (i_cfg_index == cfrm_pkg::CFG_INTERVAL) &&
                         (i_cfg_data[cfrm_pkg::IVL_W-1:0] != r_interval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval       <= cfrm_pkg::IVL_RESET;
            r_num_counters   <= cfrm_pkg::NUM_RESET;
            r_max_fifo_words <= cfrm_pkg::MAXW_RESET;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                cfrm_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[cfrm_pkg::IVL_W-1:0];
                cfrm_pkg::CFG_NUM:      r_num_counters <= i_cfg_data[cfrm_pkg::NUM_W-1:0];
                cfrm_pkg::CFG_MAXW:     r_max_fifo_words <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfrm_front #(
        .MAX_COUNTERS (MAX_COUNTERS)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_counter_index  (i_counter_index),
        .i_value          (i_value),
        .i_last_of_set    (i_last_of_set),
        .i_num_counters   (r_num_counters),
        .i_max_fifo_words (r_max_fifo_words),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_q_cmd          (w_push_cmd)
    );

    cfrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    cfrm_back #(
        .MAX_COUNTERS (MAX_COUNTERS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_head_cmd),
        .o_q_pop        (w_q_pop),
        .i_interval     (r_interval),
        .i_num_counters (r_num_counters),
        .i_drop_set     (w_drop_set),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (w_result)
    );

    assign o_result_kind   = w_result.result_kind;
    assign o_rate_index    = w_result.rate_index;
    assign o_rate_tenths   = w_result.rate_tenths;
    assign o_fifo_state    = w_result.fifo_state;
    assign o_adjusted_load = w_result.adjusted_load;
    assign o_last_rate     = w_result.last_rate;

endmodule
`default_nettype wire
